// ===== sv/pva_pkg.sv =====
// Shared types and constants for the polyphonic voice allocator.
`timescale 1ns / 1ps
package pva_pkg;

  localparam int NOTE_W = 7;
  localparam int VEL_W  = 7;
  localparam int AGE_W  = 32;
  localparam int VIDX_W = 4;

  localparam logic [AGE_W-1:0] AGE_MAX         = 32'hFFFF_FFFF;
  localparam logic [VEL_W-1:0] PEDAL_THRESHOLD = 7'd63;

  typedef enum logic [1:0] {
    OP_NOTE_ON  = 2'd0,
    OP_NOTE_OFF = 2'd1,
    OP_PEDAL    = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_PEDAL
  } state_t;

  // One voice table entry as stored in the RAM
  typedef struct packed {
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
    logic              gate;
    logic              key_down;
    logic              sus;
    logic [AGE_W-1:0]  age;
  } voice_t;

  localparam int VOICE_W = $bits(voice_t);

  // Candidates collected over one walk of the voice table
  typedef struct packed {
    logic              match_hit;
    logic [VIDX_W-1:0] match_idx;
    voice_t            match_ent;
    logic              free_hit;
    logic [VIDX_W-1:0] free_idx;
    logic              free_sus;
    logic [VIDX_W-1:0] best_idx;
    logic              best_sus;
  } scan_res_t;

endpackage

// ===== sv/pva_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/pva_scan.sv =====
// Candidate tracker: matching voice, first free voice and oldest voice.
`timescale 1ns / 1ps
module pva_scan import pva_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clr,
  input  logic              vld,
  input  logic [VIDX_W-1:0] idx,
  input  voice_t            ent,
  input  logic [NOTE_W-1:0] note,
  output scan_res_t         res
);

  logic              match_hit_r;
  logic [VIDX_W-1:0] match_idx_r;
  voice_t            match_ent_r;
  logic              free_hit_r;
  logic [VIDX_W-1:0] free_idx_r;
  logic              free_sus_r;
  logic [VIDX_W-1:0] best_idx_r;
  logic              best_sus_r;
  logic [AGE_W-1:0]  best_age_r;
  logic              is_match;
  logic              is_older;

  assign is_match = ent.gate && (ent.note == note);
  assign is_older = ent.age < best_age_r;

  // Track the first hit of each kind and the strictly smallest age
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_hit_r <= 1'b0;
      free_hit_r  <= 1'b0;
    end else if (clr) begin
      match_hit_r <= 1'b0;
      free_hit_r  <= 1'b0;
      best_age_r  <= AGE_MAX;
      best_idx_r  <= '0;
    end else if (vld) begin
      if (is_match && !match_hit_r) begin
        match_hit_r <= 1'b1;
        match_idx_r <= idx;
        match_ent_r <= ent;
      end
      if (!ent.gate && !free_hit_r) begin
        free_hit_r <= 1'b1;
        free_idx_r <= idx;
        free_sus_r <= ent.sus;
      end
      // Voice 0 is the fallback steal when no age beats the maximum
      if (is_older || idx == '0) begin
        best_sus_r <= ent.sus;
      end
      if (is_older) begin
        best_age_r <= ent.age;
        best_idx_r <= idx;
      end
    end
  end

  always_comb begin
    res.match_hit = match_hit_r;
    res.match_idx = match_idx_r;
    res.match_ent = match_ent_r;
    res.free_hit  = free_hit_r;
    res.free_idx  = free_idx_r;
    res.free_sus  = free_sus_r;
    res.best_idx  = best_idx_r;
    res.best_sus  = best_sus_r;
  end

endmodule

// ===== sv/polyphonic_voice_allocator_unit.sv =====
// Top level of the polyphonic voice allocator: sequencer around the voice RAM.
//
//  channel | ports                                  | handshake
//  --------+----------------------------------------+-----------------------------
//  input   | in_operation, in_note_number, in_amount| start & !busy accepts a beat
//  result  | out_voice_index ... out_last           | out_valid high with each beat
//
// Note on / note off: the voice table is read once per cycle, one voice a cycle,
// then the chosen entry is written back; busy stays high until that write-back
// is done. Pedal: one voice read, updated and written per cycle; busy until the
// last voice is written, one result beat per voice. Code 3 is taken and dropped.
// Results appear in the cycle after their write; the receiver cannot stall them.
// Reset clears the per-entry valid bits, so no clearing pass is needed.
`timescale 1ns / 1ps
module polyphonic_voice_allocator_unit import pva_pkg::*; #(
  parameter int VOICE_COUNT = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_operation,
  input  logic [6:0]        in_note_number,
  input  logic [6:0]        in_amount,
  output logic              out_valid,
  output logic [3:0]        out_voice_index,
  output logic [6:0]        out_voice_note,
  output logic [6:0]        out_voice_velocity,
  output logic              out_gate,
  output logic              out_held_by_pedal,
  output logic              out_matched,
  output logic              out_last
);

  localparam int IDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int CNT_W = $clog2(VOICE_COUNT + 1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(VOICE_COUNT - 1);
  localparam logic [CNT_W-1:0] CNT_VOICE = CNT_W'(VOICE_COUNT);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  ra_r, ra_nxt;
  logic [IDX_W-1:0]  da_r, da_nxt;
  op_t               op_r;
  logic [NOTE_W-1:0] note_r;
  logic [VEL_W-1:0]  amt_r;
  logic [AGE_W-1:0]  evt_cnt_r;
  logic              pedal_r, pedal_nxt;
  logic [VOICE_COUNT-1:0] vld_r;
  logic              rvld_r;

  logic              accept;
  logic              cnt_adv;
  logic              re;
  logic [IDX_W-1:0]  raddr;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  voice_t            wdata;
  logic [VOICE_W-1:0] rdata;
  voice_t            rd_ent;
  logic              scan_clr;
  logic              scan_vld;
  scan_res_t         scan_res;

  logic              emit;
  logic [VIDX_W-1:0] em_idx;
  voice_t            em_ent;
  logic              em_matched;
  logic              em_last;

  logic              out_valid_r;
  logic [VIDX_W-1:0] out_idx_r;
  logic [NOTE_W-1:0] out_note_r;
  logic [VEL_W-1:0]  out_vel_r;
  logic              out_gate_r;
  logic              out_sus_r;
  logic              out_matched_r;
  logic              out_last_r;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Voice table storage
  pva_ram #(
    .WIDTH (VOICE_W),
    .DEPTH (VOICE_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Entries never written read as the reset value
  assign rd_ent = rvld_r ? voice_t'(rdata) : '0;

  pva_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (scan_clr),
    .vld   (scan_vld),
    .idx   (VIDX_W'(da_r)),
    .ent   (rd_ent),
    .note  (note_r),
    .res   (scan_res)
  );

  // Sequencer state and walk counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      ra_r      <= '0;
      da_r      <= '0;
      pedal_r   <= 1'b0;
      evt_cnt_r <= AGE_W'(1);
      vld_r     <= '0;
    end else begin
      state_r <= state_nxt;
      ra_r    <= ra_nxt;
      da_r    <= da_nxt;
      pedal_r <= pedal_nxt;
      if (cnt_adv && evt_cnt_r != AGE_MAX) begin
        evt_cnt_r <= evt_cnt_r + 1'b1;
      end
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
    end
  end

  // Capture the accepted beat and the valid bit of each read
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= op_t'(in_operation);
      note_r <= in_note_number;
      amt_r  <= in_amount;
    end
    if (re) begin
      rvld_r <= vld_r[raddr];
    end
  end

  // Next state, RAM access and result selection
  always_comb begin
    state_nxt  = state_r;
    ra_nxt     = ra_r;
    da_nxt     = da_r;
    pedal_nxt  = pedal_r;
    cnt_adv    = 1'b0;
    re         = 1'b0;
    raddr      = ra_r[IDX_W-1:0];
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    scan_clr   = 1'b0;
    scan_vld   = 1'b0;
    emit       = 1'b0;
    em_idx     = '0;
    em_ent     = '0;
    em_matched = 1'b0;
    em_last    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && op_t'(in_operation) != OP_NONE) begin
          re       = 1'b1;
          raddr    = '0;
          ra_nxt   = CNT_W'(1);
          da_nxt   = '0;
          scan_clr = 1'b1;
          state_nxt = (op_t'(in_operation) == OP_PEDAL) ? ST_PEDAL : ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_vld = 1'b1;
        if (ra_r < CNT_VOICE) begin
          re     = 1'b1;
          ra_nxt = ra_r + 1'b1;
        end
        da_nxt = da_r + 1'b1;
        if (da_r == LAST_IDX) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        emit      = 1'b1;
        em_last   = 1'b1;
        cnt_adv   = 1'b1;
        state_nxt = ST_IDLE;
        if (op_r == OP_NOTE_ON) begin
          // Reuse the sounding voice, else the first free one, else steal the oldest
          priority if (scan_res.match_hit) begin
            em_idx     = scan_res.match_idx;
            em_ent.sus = scan_res.match_ent.sus;
          end else if (scan_res.free_hit) begin
            em_idx     = scan_res.free_idx;
            em_ent.sus = scan_res.free_sus;
          end else begin
            em_idx     = scan_res.best_idx;
            em_ent.sus = scan_res.best_sus;
          end
          em_ent.note     = note_r;
          em_ent.vel      = amt_r;
          em_ent.gate     = 1'b1;
          em_ent.key_down = 1'b1;
          em_ent.age      = evt_cnt_r;
          we    = 1'b1;
          waddr = em_idx[IDX_W-1:0];
          wdata = em_ent;
        end else if (scan_res.match_hit) begin
          // Release the voice, or only drop its key while the pedal holds it
          em_idx          = scan_res.match_idx;
          em_ent          = scan_res.match_ent;
          em_ent.key_down = 1'b0;
          if (!pedal_r) begin
            em_ent.gate = 1'b0;
            em_ent.vel  = '0;
            em_ent.note = '0;
            em_ent.age  = '0;
          end
          em_matched = 1'b1;
          we    = 1'b1;
          waddr = em_idx[IDX_W-1:0];
          wdata = em_ent;
        end
      end
      ST_PEDAL: begin
        if (ra_r < CNT_VOICE) begin
          re     = 1'b1;
          ra_nxt = ra_r + 1'b1;
        end
        da_nxt = da_r + 1'b1;
        em_ent = rd_ent;
        if (amt_r > PEDAL_THRESHOLD) begin
          em_ent.sus = rd_ent.sus | rd_ent.gate;
        end else begin
          em_ent.sus = 1'b0;
          if (!rd_ent.key_down) begin
            em_ent.gate = 1'b0;
            em_ent.vel  = '0;
            em_ent.note = '0;
            em_ent.age  = '0;
          end
        end
        we      = 1'b1;
        waddr   = da_r;
        wdata   = em_ent;
        emit    = 1'b1;
        em_idx  = VIDX_W'(da_r);
        em_last = (da_r == LAST_IDX);
        if (da_r == LAST_IDX) begin
          pedal_nxt = (amt_r > PEDAL_THRESHOLD);
          cnt_adv   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit;
    end
  end

  // Result beat payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_idx_r     <= em_idx;
      out_note_r    <= em_ent.note;
      out_vel_r     <= em_ent.vel;
      out_gate_r    <= em_ent.gate;
      out_sus_r     <= em_ent.sus;
      out_matched_r <= em_matched;
      out_last_r    <= em_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_voice_index    = out_idx_r;
  assign out_voice_note     = out_note_r;
  assign out_voice_velocity = out_vel_r;
  assign out_gate           = out_gate_r;
  assign out_held_by_pedal  = out_sus_r;
  assign out_matched        = out_matched_r;
  assign out_last           = out_last_r;

endmodule

// ===== sv/pva_chk.sv =====
// Port-level checks for the polyphonic voice allocator, bound to the top level.
`timescale 1ns / 1ps
module pva_chk import pva_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_operation,
  input logic       out_valid,
  input logic [6:0] out_voice_note,
  input logic [6:0] out_voice_velocity,
  input logic       out_gate,
  input logic       out_held_by_pedal,
  input logic       out_matched,
  input logic       out_last
);

  // A real event keeps the block busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation != OP_NONE) |=> busy)
    else $error("busy not raised after an accepted event");

  // A silent voice carries no note and no velocity
  a_silent_is_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_gate) |-> (out_voice_note == '0 && out_voice_velocity == '0))
    else $error("silent voice reports note or velocity");

  // A matched note off is a single beat
  a_matched_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_matched) |-> out_last)
    else $error("matched beat is not the last");

  // Pedal beats come back to back until the last one
  a_burst_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("gap inside a multi-beat result");

  // Only a sounding voice can be held by the pedal
  a_sus_needs_gate: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_held_by_pedal) |-> out_gate)
    else $error("held voice is not sounding");

endmodule

bind polyphonic_voice_allocator_unit pva_chk u_pva_chk (.*);

// ===== sim/tb.sv =====
// Self-checking testbench for the polyphonic voice allocator unit.
`timescale 1ns / 1ps
module tb import pva_pkg::*;;

  localparam int NUM_VOICES   = 8;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 30;
  localparam int RANDOM_ITEMS = 250;
  localparam logic [6:0] POOL_BASE = 7'd48;

  // One result beat as seen on the out_ ports
  typedef struct packed {
    logic [3:0] vidx;
    logic [6:0] note;
    logic [6:0] vel;
    logic       gate;
    logic       held;
    logic       matched;
    logic       last;
  } voice_beat_t;

  logic       clk;
  logic       rst_n          = 1'b0;
  logic       start          = 1'b0;
  logic [1:0] in_operation   = 2'd0;
  logic [6:0] in_note_number = 7'd0;
  logic [6:0] in_amount      = 7'd0;
  logic       busy;
  logic       out_valid;
  logic [3:0] out_voice_index;
  logic [6:0] out_voice_note;
  logic [6:0] out_voice_velocity;
  logic       out_gate;
  logic       out_held_by_pedal;
  logic       out_matched;
  logic       out_last;

  polyphonic_voice_allocator_unit #(.VOICE_COUNT(NUM_VOICES)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_operation       (in_operation),
    .in_note_number     (in_note_number),
    .in_amount          (in_amount),
    .out_valid          (out_valid),
    .out_voice_index    (out_voice_index),
    .out_voice_note     (out_voice_note),
    .out_voice_velocity (out_voice_velocity),
    .out_gate           (out_gate),
    .out_held_by_pedal  (out_held_by_pedal),
    .out_matched        (out_matched),
    .out_last           (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Shadow voice table
  logic [6:0]  sh_note [NUM_VOICES];
  logic [6:0]  sh_vel  [NUM_VOICES];
  logic        sh_gate [NUM_VOICES];
  logic        sh_key  [NUM_VOICES];
  logic        sh_sus  [NUM_VOICES];
  logic [31:0] sh_age  [NUM_VOICES];
  logic [31:0] sh_clock;
  logic        sh_pedal;

  voice_beat_t pending_voice_beats[$];

  int mismatches   = 0;
  int beats_seen   = 0;
  int n_note_on    = 0;
  int n_note_off   = 0;
  int n_unmatched  = 0;
  int n_pedal      = 0;
  int n_ignored    = 0;
  int n_steals     = 0;
  int idle_cycles  = 0;
  bit no_idle      = 1'b0;

  function automatic void clear_voice_table();
    for (int i = 0; i < NUM_VOICES; i++) begin
      sh_note[i] = '0;
      sh_vel[i]  = '0;
      sh_gate[i] = 1'b0;
      sh_key[i]  = 1'b0;
      sh_sus[i]  = 1'b0;
      sh_age[i]  = '0;
    end
    sh_clock = 32'd1;
    sh_pedal = 1'b0;
  endfunction

  function automatic int sounding_voice(logic [6:0] note);
    for (int i = 0; i < NUM_VOICES; i++)
      if (sh_gate[i] && sh_note[i] == note) return i;
    return -1;
  endfunction

  function automatic voice_beat_t voice_beat(int v, logic matched, logic last);
    voice_beat_t b;
    b.vidx    = v[3:0];
    b.note    = sh_note[v];
    b.vel     = sh_vel[v];
    b.gate    = sh_gate[v];
    b.held    = sh_sus[v];
    b.matched = matched;
    b.last    = last;
    return b;
  endfunction

  function automatic void release_voice(int v);
    sh_gate[v] = 1'b0;
    sh_vel[v]  = '0;
    sh_note[v] = '0;
    sh_age[v]  = '0;
  endfunction

  // Apply one event to the shadow table and queue the beats it should produce
  function automatic void allocate_and_predict(op_t op, logic [6:0] note, logic [6:0] amount);
    int v;
    logic [31:0] best_age;
    case (op)
      OP_NOTE_ON: begin
        n_note_on++;
        v = sounding_voice(note);
        if (v < 0) begin
          for (int i = NUM_VOICES - 1; i >= 0; i--)
            if (!sh_gate[i]) v = i;
        end
        // All voices sound: steal the oldest, lowest index on a tie
        if (v < 0) begin
          n_steals++;
          v = 0;
          best_age = AGE_MAX;
          for (int i = 0; i < NUM_VOICES; i++)
            if (sh_age[i] < best_age) begin
              best_age = sh_age[i];
              v = i;
            end
        end
        sh_age[v]  = sh_clock;
        sh_note[v] = note;
        sh_vel[v]  = amount;
        sh_gate[v] = 1'b1;
        sh_key[v]  = 1'b1;
        pending_voice_beats.push_back(voice_beat(v, 1'b0, 1'b1));
      end
      OP_NOTE_OFF: begin
        n_note_off++;
        v = sounding_voice(note);
        if (v >= 0) begin
          sh_key[v] = 1'b0;
          if (!sh_pedal) release_voice(v);
          pending_voice_beats.push_back(voice_beat(v, 1'b1, 1'b1));
        end else begin
          n_unmatched++;
          pending_voice_beats.push_back('{vidx: '0, note: '0, vel: '0, gate: 1'b0,
                                          held: 1'b0, matched: 1'b0, last: 1'b1});
        end
      end
      OP_PEDAL: begin
        n_pedal++;
        if (amount > PEDAL_THRESHOLD) begin
          sh_pedal = 1'b1;
          for (int i = 0; i < NUM_VOICES; i++)
            if (sh_gate[i]) sh_sus[i] = 1'b1;
        end else begin
          sh_pedal = 1'b0;
          for (int i = 0; i < NUM_VOICES; i++) begin
            sh_sus[i] = 1'b0;
            if (!sh_key[i]) release_voice(i);
          end
        end
        for (int i = 0; i < NUM_VOICES; i++)
          pending_voice_beats.push_back(voice_beat(i, 1'b0, i == NUM_VOICES - 1));
      end
      default: begin
        // Unused code: no state change, no clock advance
        n_ignored++;
        return;
      end
    endcase
    if (sh_clock != AGE_MAX) sh_clock++;
  endfunction

  // Send one beat on the input channel and predict it once accepted
  task automatic issue_event(op_t op, logic [6:0] note, logic [6:0] amount);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_operation   <= op;
    in_note_number <= note;
    in_amount      <= amount;
    do @(posedge clk); while (busy !== 1'b0);
    allocate_and_predict(op, note, amount);
  endtask

  task automatic report_mismatch(string what, voice_beat_t want, voice_beat_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch (%s): exp idx=%0d note=%0d vel=%0d gate=%0b sus=%0b m=%0b l=%0b",
               $realtime, what, want.vidx, want.note, want.vel, want.gate, want.held,
               want.matched, want.last);
    if (mismatches <= 10)
      $display("%0t              got idx=%0d note=%0d vel=%0d gate=%0b sus=%0b m=%0b l=%0b",
               $realtime, got.vidx, got.note, got.vel, got.gate, got.held,
               got.matched, got.last);
  endtask

  // Compare every result beat with the oldest prediction
  always @(posedge clk) begin : check_beats
    voice_beat_t got;
    voice_beat_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      beats_seen++;
      got = '{vidx: out_voice_index, note: out_voice_note, vel: out_voice_velocity,
              gate: out_gate, held: out_held_by_pedal, matched: out_matched,
              last: out_last};
      if (pending_voice_beats.size() == 0) begin
        report_mismatch("unexpected beat", '0, got);
      end else begin
        want = pending_voice_beats.pop_front();
        if (got !== want) report_mismatch("wrong field", want, got);
      end
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_field_extremes();
    issue_event(OP_NOTE_ON, 7'd0, 7'd0);
    issue_event(OP_NOTE_ON, 7'd127, 7'd127);
    issue_event(OP_NOTE_OFF, 7'd0, 7'd127);
    issue_event(OP_NOTE_OFF, 7'd127, 7'd0);
  endtask

  task automatic test_unmatched_off();
    issue_event(OP_NOTE_OFF, 7'd55, 7'd33);
  endtask

  task automatic test_note_reuse();
    issue_event(OP_NOTE_ON, 7'd60, 7'd10);
    issue_event(OP_NOTE_ON, 7'd60, 7'd90);
  endtask

  task automatic test_fill_and_steal();
    // Fill the remaining voices, then one more note takes the oldest
    for (int i = 1; i <= NUM_VOICES; i++)
      issue_event(OP_NOTE_ON, 7'(60 + i), 7'(i * 13));
  endtask

  task automatic test_sustain_pedal();
    issue_event(OP_PEDAL, 7'd3, 7'd64);
    issue_event(OP_NOTE_OFF, 7'd65, 7'd0);
    issue_event(OP_NOTE_OFF, 7'd65, 7'd0);
    issue_event(OP_PEDAL, 7'd0, 7'd63);
    issue_event(OP_PEDAL, 7'd0, 7'd127);
    issue_event(OP_PEDAL, 7'd127, 7'd0);
  endtask

  task automatic test_unused_code();
    issue_event(OP_NONE, 7'd127, 7'd127);
  endtask

  task automatic test_random_events();
    int done;
    int pick;
    int held_notes[$];
    op_t op;
    logic [6:0] note;
    logic [6:0] amount;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      // Switch between idling and back-to-back stretches
      if (done % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      pick   = $urandom_range(0, 99);
      note   = POOL_BASE + 7'($urandom_range(0, 15));
      amount = 7'($urandom_range(0, 127));
      if (pick < 45) begin
        op = OP_NOTE_ON;
      end else if (pick < 70) begin
        // Release a note that is sounding now
        op = OP_NOTE_OFF;
        held_notes.delete();
        for (int i = 0; i < NUM_VOICES; i++)
          if (sh_gate[i]) held_notes.push_back(sh_note[i]);
        if (held_notes.size() > 0)
          note = 7'(held_notes[$urandom_range(0, held_notes.size() - 1)]);
      end else if (pick < 80) begin
        op = OP_NOTE_OFF;
      end else if (pick < 90) begin
        op = OP_PEDAL;
        case ($urandom_range(0, 3))
          0: amount = 7'd63;
          1: amount = 7'd64;
          2: amount = 7'($urandom_range(0, 63));
          default: amount = 7'($urandom_range(64, 127));
        endcase
      end else if (pick < 97) begin
        op   = op_t'($urandom_range(0, 2));
        note = 7'($urandom_range(0, 127));
      end else begin
        op   = OP_NONE;
        note = 7'($urandom_range(0, 127));
      end
      issue_event(op, note, amount);
      if (op != OP_NONE) done++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    clear_voice_table();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_unmatched_off();
    test_note_reuse();
    test_fill_and_steal();
    test_sustain_pedal();
    test_unused_code();
    test_random_events();

    start <= 1'b0;
    while (pending_voice_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d note-on (%0d steals), %0d note-off (%0d unmatched), %0d pedal",
             n_note_on, n_steals, n_note_off, n_unmatched, n_pedal);
    $display("ignored codes: %0d, result beats checked: %0d, mismatches: %0d",
             n_ignored, beats_seen, mismatches);
    if (mismatches == 0 && pending_voice_beats.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
